// ===== rtl/ajfs_pkg.sv =====
package ajfs_pkg;

    // joining classes
    localparam logic [2:0] CL_U = 3'd0;
    localparam logic [2:0] CL_T = 3'd1;
    localparam logic [2:0] CL_R = 3'd2;
    localparam logic [2:0] CL_L = 3'd3;
    localparam logic [2:0] CL_D = 3'd4;
    localparam logic [2:0] CL_C = 3'd5;

    // contextual forms
    localparam logic [1:0] FORM_ISOLATED = 2'd0;
    localparam logic [1:0] FORM_FINAL    = 2'd1;
    localparam logic [1:0] FORM_INITIAL  = 2'd2;
    localparam logic [1:0] FORM_MEDIAL   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_LINK_BEFORE   = 2'd0;
    localparam logic [1:0] CFG_LINK_AFTER    = 2'd1;
    localparam logic [1:0] CFG_REVERSE_ORDER = 2'd2;

    localparam int WAIT_W          = 6;
    localparam int MAX_WAITING_DEF = 32;

    typedef logic [WAIT_W-1:0] wait_cnt_t;

    typedef struct packed {
        logic link_before;
        logic link_after;
        logic reverse_order;
    } cfg_t;

    // one transaction's results: optional leading form, a run of isolated
    // transparent characters, optional trailing form
    typedef struct packed {
        logic      a_pend;
        logic [1:0] a_form;
        wait_cnt_t z_cnt;
        logic      b_pend;
        logic [1:0] b_form;
        logic      text_end;
    } burst_t;

    function automatic logic [1:0] pick_form(logic [2:0] t, logic [2:0] prev,
                                             logic [2:0] next, logic rev);
        logic [2:0] right;
        logic [2:0] left;
        logic       r;
        logic       l;
        logic [1:0] f;
        right = rev ? next : prev;
        left  = rev ? prev : next;
        r = right inside {CL_L, CL_D, CL_C};
        l = left inside {CL_R, CL_D, CL_C};
        f = FORM_ISOLATED;
        case (t)
            CL_R: if (r) f = FORM_FINAL;
            CL_L: if (l) f = FORM_INITIAL;
            CL_D:
            begin
                if (l && r)
                    f = FORM_MEDIAL;
                else if (r)
                    f = FORM_FINAL;
                else if (l)
                    f = FORM_INITIAL;
            end
            default: f = FORM_ISOLATED;
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/ajfs_decide.sv =====
module ajfs_decide #(
    parameter int MAX_WAITING = ajfs_pkg::MAX_WAITING_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [2:0]        join_class,
    input  logic              text_end,
    input  ajfs_pkg::cfg_t    cfg,
    output ajfs_pkg::burst_t  burst
);

    localparam ajfs_pkg::wait_cnt_t WAIT_LIMIT = ajfs_pkg::wait_cnt_t'(MAX_WAITING);

    logic [2:0]          prior_class_reg, prior_class_next;
    logic [2:0]          held_class_reg, held_class_next;
    logic                held_valid_reg, held_valid_next;
    ajfs_pkg::wait_cnt_t waiting_count_reg, waiting_count_next;
    logic                at_text_start_reg, at_text_start_next;

    logic [2:0] cls;
    logic [2:0] prev;
    logic [2:0] prev_new;
    logic [2:0] after;

    always_comb
    begin
        cls   = (join_class > ajfs_pkg::CL_C) ? ajfs_pkg::CL_U : join_class;
        prev  = at_text_start_reg ? (cfg.link_before ? ajfs_pkg::CL_R : ajfs_pkg::CL_U)
                                  : prior_class_reg;
        after = cfg.link_after ? ajfs_pkg::CL_L : ajfs_pkg::CL_U;
        // previous neighbor of the incoming character when it is decided at once
        prev_new = held_valid_reg ? held_class_reg : prev;

        burst              = '0;
        burst.text_end     = text_end;
        prior_class_next   = prior_class_reg;
        held_class_next    = held_class_reg;
        held_valid_next    = held_valid_reg;
        waiting_count_next = waiting_count_reg;
        at_text_start_next = at_text_start_reg;

        if (cls == ajfs_pkg::CL_T)
        begin
            if (held_valid_reg && !text_end && waiting_count_reg < WAIT_LIMIT)
            begin
                waiting_count_next = waiting_count_reg + 1'b1;
            end
            else
            begin
                if (held_valid_reg)
                begin
                    burst.a_pend = 1'b1;
                    burst.a_form = ajfs_pkg::pick_form(held_class_reg, prev,
                                       text_end ? after : ajfs_pkg::CL_U,
                                       cfg.reverse_order);
                    burst.z_cnt  = waiting_count_reg;
                    prior_class_next   = held_class_reg;
                    at_text_start_next = 1'b0;
                    held_valid_next    = 1'b0;
                    held_class_next    = ajfs_pkg::CL_U;
                    waiting_count_next = '0;
                end
                burst.b_pend = 1'b1;
                burst.b_form = ajfs_pkg::FORM_ISOLATED;
            end
        end
        else
        begin
            if (held_valid_reg)
            begin
                burst.a_pend = 1'b1;
                burst.a_form = ajfs_pkg::pick_form(held_class_reg, prev, cls,
                                                   cfg.reverse_order);
                burst.z_cnt  = waiting_count_reg;
                prior_class_next   = held_class_reg;
                at_text_start_next = 1'b0;
            end
            held_class_next    = cls;
            held_valid_next    = 1'b1;
            waiting_count_next = '0;
            if (text_end)
            begin
                burst.b_pend = 1'b1;
                burst.b_form = ajfs_pkg::pick_form(cls, prev_new, after, cfg.reverse_order);
            end
        end

        // end of text returns the text state to its start values
        if (text_end)
        begin
            prior_class_next   = ajfs_pkg::CL_U;
            held_class_next    = ajfs_pkg::CL_U;
            held_valid_next    = 1'b0;
            waiting_count_next = '0;
            at_text_start_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_class_reg   <= ajfs_pkg::CL_U;
            held_class_reg    <= ajfs_pkg::CL_U;
            held_valid_reg    <= 1'b0;
            waiting_count_reg <= '0;
            at_text_start_reg <= 1'b1;
        end
        else if (accept)
        begin
            prior_class_reg   <= prior_class_next;
            held_class_reg    <= held_class_next;
            held_valid_reg    <= held_valid_next;
            waiting_count_reg <= waiting_count_next;
            at_text_start_reg <= at_text_start_next;
        end
    end

endmodule

// ===== rtl/ajfs_emit.sv =====
module ajfs_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  ajfs_pkg::burst_t burst_in,
    output logic             can_load,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       form,
    output logic             final_of_text,
    output logic             run_last
);

    ajfs_pkg::burst_t burst_reg, burst_next;

    logic z_zero;
    logic z_one;
    logic last;
    logic taken;

    always_comb
    begin
        z_zero = (burst_reg.z_cnt == '0);
        z_one  = (burst_reg.z_cnt == ajfs_pkg::wait_cnt_t'(1));

        out_valid = burst_reg.a_pend || !z_zero || burst_reg.b_pend;
        // exactly one result left
        last = (burst_reg.a_pend && z_zero && !burst_reg.b_pend)
            || (!burst_reg.a_pend && z_one && !burst_reg.b_pend)
            || (!burst_reg.a_pend && z_zero && burst_reg.b_pend);

        if (burst_reg.a_pend)
            form = burst_reg.a_form;
        else if (!z_zero)
            form = ajfs_pkg::FORM_ISOLATED;
        else
            form = burst_reg.b_form;

        run_last      = last;
        final_of_text = last && burst_reg.text_end;

        taken    = out_valid && !out_stall;
        can_load = !out_valid || (last && !out_stall);

        burst_next = burst_reg;
        if (load)
            burst_next = burst_in;
        else if (taken)
        begin
            if (burst_reg.a_pend)
                burst_next.a_pend = 1'b0;
            else if (!z_zero)
                burst_next.z_cnt = burst_reg.z_cnt - 1'b1;
            else
                burst_next.b_pend = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            burst_reg <= '0;
        else
            burst_reg <= burst_next;
    end

endmodule

// ===== rtl/arabic_joining_form_select_top.sv =====
// Arabic joining form selection: one character per input transaction as a
// joining class, one contextual form per character out, in text order. An
// input transaction is taken every cycle while the output is not stalled and
// each one yields at most one result; a transaction that releases a held
// character together with the transparent characters waiting behind it
// yields up to MAX_WAITING + 2 results, one per cycle from the result
// register while the output is not stalled, and input stalls until the last
// of them leaves. Decisions use the configuration in force when the
// transaction is taken. Configuration writes are registered and never stalled.
module arabic_joining_form_select_top #(
    parameter int MAX_WAITING = ajfs_pkg::MAX_WAITING_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // character input
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] join_class,
    input  logic       text_end,
    // form output
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] form,
    output logic       final_of_text,
    output logic       run_last,
    // configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic       cfg_data
);

    ajfs_pkg::cfg_t   cfg_reg;
    ajfs_pkg::burst_t burst;
    logic             can_load;
    logic             accept;

    // configuration is always writable; an index past the last register is dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ajfs_pkg::CFG_LINK_BEFORE:   cfg_reg.link_before   <= cfg_data;
                ajfs_pkg::CFG_LINK_AFTER:    cfg_reg.link_after    <= cfg_data;
                ajfs_pkg::CFG_REVERSE_ORDER: cfg_reg.reverse_order <= cfg_data;
                default:                     cfg_reg <= cfg_reg;
            endcase
        end
    end

    // a new transaction loads the result register when it is empty or its
    // last result leaves this cycle
    assign in_stall = !can_load;
    assign accept   = in_valid && can_load;

    // text state and per-transaction result plan
    ajfs_decide #(
        .MAX_WAITING (MAX_WAITING)
    ) u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .join_class (join_class),
        .text_end   (text_end),
        .cfg        (cfg_reg),
        .burst      (burst)
    );

    // result register, streams the plan one form per cycle while the output is not stalled
    ajfs_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .burst_in      (burst),
        .can_load      (can_load),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .form          (form),
        .final_of_text (final_of_text),
        .run_last      (run_last)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    // counter depth used for both the block and the predictor
    localparam int MAX_WAIT = ajfs_pkg::MAX_WAITING_DEF;
    // watchdog, far above the slowest legal run
    localparam int CYCLE_LIMIT = 400000;
    // codes outside the defined classes, treated as U by the block
    localparam logic [2:0] CL_UNDEF6 = 3'd6;
    localparam logic [2:0] CL_UNDEF7 = 3'd7;
    // random stimulus stops once this many characters went in
    localparam int CHAR_TARGET = 280;

    // one expected form transaction
    typedef struct packed {
        logic [1:0] form;
        logic       is_final;
        logic       is_last;
    } form_rec_t;

    typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_t;

    // directed script row: a character (code = class, bitv = text end)
    // or a register write (code = index, bitv = data); pinned rows carry
    // a typed-in form for their single result
    typedef struct packed {
        row_kind_t  kind;
        logic [2:0] code;
        logic       bitv;
        logic       pin;
        logic [1:0] pin_form;
    } script_row_t;

    localparam int SCRIPT_LEN = 29;
    localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
        // reset configuration: single-character texts are always isolated
        '{ROW_CHAR, ajfs_pkg::CL_U, 1'b1, 1'b1, ajfs_pkg::FORM_ISOLATED},
        '{ROW_CHAR, ajfs_pkg::CL_T, 1'b1, 1'b1, ajfs_pkg::FORM_ISOLATED},
        '{ROW_CHAR, CL_UNDEF7,      1'b1, 1'b1, ajfs_pkg::FORM_ISOLATED},
        // dual-joining chain
        '{ROW_CHAR, ajfs_pkg::CL_D, 1'b0, 1'b0, ajfs_pkg::FORM_ISOLATED},
        '{ROW_CHAR, ajfs_pkg::CL_D, 1'b0, 1'b0, ajfs_pkg::FORM_ISOLATED},
        '{ROW_CHAR, ajfs_pkg::CL_D, 1'b1, 1'b0, ajfs_pkg::FORM_ISOLATED},
        // transparent characters skipped by the neighbor lookup
        '{ROW_CHAR, ajfs_pkg::CL_R, 1'b0, 1'b0, ajfs_pkg::FORM_ISOLATED},
        '{ROW_CHAR, ajfs_pkg::CL_T, 1'b0, 1'b0, ajfs_pkg::FORM_ISOLATED},
        '{ROW_CHAR, ajfs_pkg::CL_T, 1'b0, 1'b0, ajfs_pkg::FORM_ISOLATED},
        '{ROW_CHAR, ajfs_pkg::CL_L, 1'b1, 1'b0, ajfs_pkg::FORM_ISOLATED},
        // undefined code in the middle of a text, join causing
        '{ROW_CHAR, CL_UNDEF6,      1'b0, 1'b0, ajfs_pkg::FORM_ISOLATED},
        '{ROW_CHAR, ajfs_pkg::CL_C, 1'b0, 1'b0, ajfs_pkg::FORM_ISOLATED},
        '{ROW_CHAR, ajfs_pkg::CL_D, 1'b1, 1'b0, ajfs_pkg::FORM_ISOLATED},
        // every register at its upper extreme
        '{ROW_CFG,  3'(ajfs_pkg::CFG_LINK_BEFORE),   1'b1, 1'b0, ajfs_pkg::FORM_ISOLATED},
        '{ROW_CFG,  3'(ajfs_pkg::CFG_LINK_AFTER),    1'b1, 1'b0, ajfs_pkg::FORM_ISOLATED},
        '{ROW_CFG,  3'(ajfs_pkg::CFG_REVERSE_ORDER), 1'b1, 1'b0, ajfs_pkg::FORM_ISOLATED},
        // linked on both sides, right neighbor is the next character
        '{ROW_CHAR, ajfs_pkg::CL_D, 1'b1, 1'b1, ajfs_pkg::FORM_MEDIAL},
        '{ROW_CHAR, ajfs_pkg::CL_R, 1'b1, 1'b1, ajfs_pkg::FORM_FINAL},
        '{ROW_CHAR, ajfs_pkg::CL_L, 1'b1, 1'b1, ajfs_pkg::FORM_INITIAL},
        '{ROW_CHAR, ajfs_pkg::CL_C, 1'b1, 1'b1, ajfs_pkg::FORM_ISOLATED},
        '{ROW_CHAR, ajfs_pkg::CL_L, 1'b0, 1'b0, ajfs_pkg::FORM_ISOLATED},
        '{ROW_CHAR, ajfs_pkg::CL_T, 1'b0, 1'b0, ajfs_pkg::FORM_ISOLATED},
        '{ROW_CHAR, ajfs_pkg::CL_D, 1'b0, 1'b0, ajfs_pkg::FORM_ISOLATED},
        '{ROW_CHAR, ajfs_pkg::CL_R, 1'b1, 1'b0, ajfs_pkg::FORM_ISOLATED},
        // logical order with links still on
        '{ROW_CFG,  3'(ajfs_pkg::CFG_REVERSE_ORDER), 1'b0, 1'b0, ajfs_pkg::FORM_ISOLATED},
        '{ROW_CHAR, ajfs_pkg::CL_D, 1'b0, 1'b0, ajfs_pkg::FORM_ISOLATED},
        '{ROW_CHAR, ajfs_pkg::CL_D, 1'b1, 1'b0, ajfs_pkg::FORM_ISOLATED},
        '{ROW_CFG,  3'(ajfs_pkg::CFG_LINK_BEFORE),   1'b0, 1'b0, ajfs_pkg::FORM_ISOLATED},
        '{ROW_CFG,  3'(ajfs_pkg::CFG_LINK_AFTER),    1'b0, 1'b0, ajfs_pkg::FORM_ISOLATED}
    };

    // block inputs, known from time zero
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [2:0] join_class = ajfs_pkg::CL_U;
    logic       text_end = 1'b0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [1:0] cfg_index = ajfs_pkg::CFG_LINK_BEFORE;
    logic       cfg_data = 1'b0;

    // block outputs
    logic       in_stall;
    logic       out_valid;
    logic [1:0] form;
    logic       final_of_text;
    logic       run_last;
    logic       cfg_ready;

    // predictor: register mirror and joining context
    ajfs_pkg::cfg_t cfg_now = '0;
    logic [2:0] prior_cls = ajfs_pkg::CL_U;
    logic [2:0] held_cls = ajfs_pkg::CL_U;
    logic       held_vld = 1'b0;
    int         wait_cnt = 0;
    logic       at_start = 1'b1;

    // forms still to come out of the block, oldest first
    form_rec_t  form_q[$];
    // forms released by the transaction being predicted
    logic [1:0] step_forms[$];

    // traffic shaping
    bit         quiet = 1'b0;
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         stall_left = 0;

    // bookkeeping
    int         fails = 0;
    int         cycles = 0;
    int         n_chars = 0;
    int         n_texts = 0;
    int         n_forms = 0;
    int         n_cfg = 0;
    int         n_full = 0;
    int         n_undef = 0;

    arabic_joining_form_select_top #(
        .MAX_WAITING(MAX_WAIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .join_class(join_class),
        .text_end(text_end),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .form(form),
        .final_of_text(final_of_text),
        .run_last(run_last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d forms outstanding", cycles, form_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_fail(input string msg);
        begin
            fails++;
            if (fails <= 10)
                $display("%0t ns: %s", $time, msg);
        end
    endtask

    // contextual form of one character given its two non-transparent neighbors
    function automatic logic [1:0] joining_form(input logic [2:0] self,
                                                input logic [2:0] prev_c,
                                                input logic [2:0] next_c);
        logic [2:0] on_right;
        logic [2:0] on_left;
        logic       link_r;
        logic       link_l;
        begin
            // visual order decides which neighbor sits on which side
            on_right = cfg_now.reverse_order ? next_c : prev_c;
            on_left  = cfg_now.reverse_order ? prev_c : next_c;
            link_r = (on_right == ajfs_pkg::CL_L) || (on_right == ajfs_pkg::CL_D)
                  || (on_right == ajfs_pkg::CL_C);
            link_l = (on_left == ajfs_pkg::CL_R) || (on_left == ajfs_pkg::CL_D)
                  || (on_left == ajfs_pkg::CL_C);
            case (self)
                ajfs_pkg::CL_R: return link_r ? ajfs_pkg::FORM_FINAL : ajfs_pkg::FORM_ISOLATED;
                ajfs_pkg::CL_L: return link_l ? ajfs_pkg::FORM_INITIAL : ajfs_pkg::FORM_ISOLATED;
                ajfs_pkg::CL_D:
                begin
                    if (link_r)
                        return link_l ? ajfs_pkg::FORM_MEDIAL : ajfs_pkg::FORM_FINAL;
                    return link_l ? ajfs_pkg::FORM_INITIAL : ajfs_pkg::FORM_ISOLATED;
                end
                default: return ajfs_pkg::FORM_ISOLATED;
            endcase
        end
    endfunction

    // decide the held character against next_c, then its waiting transparents
    task automatic release_held(input logic [2:0] next_c);
        logic [2:0] prev_c;
        begin
            // before the first decision of a text the link register stands in
            prev_c = at_start ? (cfg_now.link_before ? ajfs_pkg::CL_R : ajfs_pkg::CL_U)
                              : prior_cls;
            step_forms.push_back(joining_form(held_cls, prev_c, next_c));
            repeat (wait_cnt) step_forms.push_back(ajfs_pkg::FORM_ISOLATED);
            prior_cls = held_cls;
            at_start = 1'b0;
            held_vld = 1'b0;
            held_cls = ajfs_pkg::CL_U;
            wait_cnt = 0;
        end
    endtask

    // expected forms for one accepted character transaction
    task automatic predict_forms(input logic [2:0] code, input logic last_char);
        logic [2:0] cls;
        logic [2:0] beyond;
        form_rec_t  rec;
        int         n;
        begin
            step_forms.delete();
            cls = (code > ajfs_pkg::CL_C) ? ajfs_pkg::CL_U : code;
            if (code > ajfs_pkg::CL_C)
                n_undef++;
            beyond = cfg_now.link_after ? ajfs_pkg::CL_L : ajfs_pkg::CL_U;
            if (cls == ajfs_pkg::CL_T && held_vld && !last_char && wait_cnt < MAX_WAIT)
                wait_cnt++;
            else
            begin
                if (cls == ajfs_pkg::CL_T)
                begin
                    if (held_vld && last_char)
                        release_held(beyond);
                    else if (held_vld)
                    begin
                        // wait counter full: next neighbor taken as U
                        n_full++;
                        release_held(ajfs_pkg::CL_U);
                    end
                    step_forms.push_back(ajfs_pkg::FORM_ISOLATED);
                end
                else
                begin
                    if (held_vld)
                        release_held(cls);
                    held_cls = cls;
                    held_vld = 1'b1;
                    wait_cnt = 0;
                    if (last_char)
                        release_held(beyond);
                end
                n = step_forms.size();
                for (int i = 0; i < n; i++)
                begin
                    rec.form = step_forms[i];
                    rec.is_final = last_char && (i == n - 1);
                    rec.is_last = (i == n - 1);
                    form_q.push_back(rec);
                end
                if (last_char)
                begin
                    n_texts++;
                    prior_cls = ajfs_pkg::CL_U;
                    held_cls = ajfs_pkg::CL_U;
                    held_vld = 1'b0;
                    wait_cnt = 0;
                    at_start = 1'b1;
                end
            end
        end
    endtask

    // one character transaction, with an optional idle burst in front
    task automatic send_char(input logic [2:0] code, input logic last_char);
        begin
            cfg_valid <= 1'b0;
            if (!quiet && $urandom_range(99) < idle_pct)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            in_valid <= 1'b1;
            join_class <= code;
            text_end <= last_char;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            predict_forms(code, last_char);
            n_chars++;
        end
    endtask

    // register write transaction; valid is left high for a following write
    task automatic write_reg(input logic [1:0] idx, input logic val);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx)
                ajfs_pkg::CFG_LINK_BEFORE:   cfg_now.link_before = val;
                ajfs_pkg::CFG_LINK_AFTER:    cfg_now.link_after = val;
                ajfs_pkg::CFG_REVERSE_ORDER: cfg_now.reverse_order = val;
                default: ;
            endcase
            n_cfg++;
        end
    endtask

    // stop driving, let every expected form drain, then a short settle
    task automatic wait_drained();
        begin
            in_valid <= 1'b0;
            cfg_valid <= 1'b0;
            @(posedge clk);
            while (form_q.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    // weighted toward joining classes, with transparent and odd codes mixed in
    function automatic logic [2:0] random_class();
        int r;
        begin
            r = $urandom_range(99);
            if (r < 8)  return ajfs_pkg::CL_U;
            if (r < 24) return ajfs_pkg::CL_T;
            if (r < 42) return ajfs_pkg::CL_R;
            if (r < 57) return ajfs_pkg::CL_L;
            if (r < 80) return ajfs_pkg::CL_D;
            if (r < 90) return ajfs_pkg::CL_C;
            return 3'($urandom_range(7));
        end
    endfunction

    // one text of random content, now and then with a long transparent run
    // close to the wait counter depth
    task automatic random_text();
        int         len;
        int         run;
        logic [2:0] code;
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
            begin
                code = random_class();
                send_char(code, k == len - 1);
                if (k < len - 1 && code != ajfs_pkg::CL_T && $urandom_range(13) == 0)
                begin
                    run = $urandom_range(MAX_WAIT - 3, MAX_WAIT + 3);
                    repeat (run) send_char(ajfs_pkg::CL_T, 1'b0);
                end
            end
        end
    endtask

    // output side back-pressure in random bursts
    always @(posedge clk)
    begin
        if (!rst_n || quiet)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(99) < stall_pct)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(5);
        end
        else
            out_stall <= 1'b0;
    end

    // compare every accepted form transaction with the oldest expectation
    always @(posedge clk)
    begin : form_check
        form_rec_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_forms++;
            if (form_q.size() == 0)
                report_fail($sformatf("unexpected form %0d final %0b last %0b",
                                      form, final_of_text, run_last));
            else
            begin
                want = form_q.pop_front();
                if (want.form !== form || want.is_final !== final_of_text ||
                    want.is_last !== run_last)
                    report_fail($sformatf(
                        "form mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                        want.form, want.is_final, want.is_last,
                        form, final_of_text, run_last));
            end
        end
    end

    initial
    begin : stimulus
        script_row_t row;
        form_rec_t   rec;
        int          phase_goal;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed script, reset configuration in force at first
        idle_pct = 20;
        stall_pct = 20;
        for (int r = 0; r < SCRIPT_LEN; r++)
        begin
            row = SCRIPT[r];
            if (row.kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(row.code[1:0], row.bitv);
            end
            else
            begin
                send_char(row.code, row.bitv);
                if (row.pin)
                begin
                    // single-character text: its one form is typed in above
                    rec = form_q.pop_back();
                    rec.form = row.pin_form;
                    form_q.push_back(rec);
                end
            end
        end

        // random phases, each under its own configuration and traffic mix
        for (int p = 0; p < 8; p++)
        begin
            wait_drained();
            quiet = (p == 7);
            idle_pct = (p % 3 == 2) ? 0 : $urandom_range(10, 45);
            stall_pct = (p % 3 == 1) ? 0 : $urandom_range(10, 45);
            if (p < 2)
            begin
                write_reg(ajfs_pkg::CFG_LINK_BEFORE, p == 0);
                write_reg(ajfs_pkg::CFG_LINK_AFTER, p == 0);
                write_reg(ajfs_pkg::CFG_REVERSE_ORDER, p == 0);
            end
            else
            begin
                write_reg(ajfs_pkg::CFG_LINK_BEFORE, 1'($urandom_range(1)));
                write_reg(ajfs_pkg::CFG_LINK_AFTER, 1'($urandom_range(1)));
                write_reg(ajfs_pkg::CFG_REVERSE_ORDER, 1'($urandom_range(1)));
            end
            if (p == 0)
            begin
                // overflow the wait counter behind a held dual-joining character
                send_char(ajfs_pkg::CL_D, 1'b0);
                repeat (MAX_WAIT + 1) send_char(ajfs_pkg::CL_T, 1'b0);
                send_char(ajfs_pkg::CL_L, 1'b1);
            end
            phase_goal = (p == 7) ? CHAR_TARGET : n_chars + (CHAR_TARGET - n_chars) / (8 - p);
            while (n_chars < phase_goal)
                random_text();
        end

        wait_drained();
        if (form_q.size() != 0)
            report_fail($sformatf("%0d forms never came out", form_q.size()));

        $display("%0d characters in %0d texts, %0d forms checked, %0d register writes",
                 n_chars, n_texts, n_forms, n_cfg);
        $display("%0d wait counter overflows, %0d undefined class codes, %0d mismatches",
                 n_full, n_undef, fails);
        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
